// ===== rtl/etrm_pkg.sv =====
// Shared types and constants for the execution-range packet merger.
package etrm_pkg;

  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned DUR_W   = 32;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned HALF_W  = 32;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_BARRIER = 2'd2
  } kind_e;

  typedef enum logic {
    REQ_RANGE = 1'b0,
    REQ_FLUSH = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_HDR,
    S_ENT,
    S_BAR,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic take;
    logic apply;
    logic load_hdr;
    logic load_ent;
    logic load_bar;
  } cmd_t;

  typedef struct packed {
    logic flush;
    logic cnt_zero;
    logic unit_chg;
    logic fill;
    logic ent_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/exec_trace_range_merger_top.sv =====
// Top level of the execution-range packet merger.
// A range record is accepted, then merged or appended; any packet emit it causes also completes before ready returns.
// A packet of n entries is emitted as n + 2 results, one per cycle while the
// sink is ready; entries stream from the entry memory one read per cycle.
// A unit change emits the old packet first, then appends the new record in S_APPLY.
// rst_ni clears the fill count, unit and packet time; entry storage is not cleared.
module exec_trace_range_merger_top
  import etrm_pkg::*;
#(
  parameter int unsigned CACHE_DEPTH = 32,
  parameter int unsigned PAGE_BITS   = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [UNIT_W-1:0]  unit_id_i,
  input  logic [ADDR_W-1:0]  range_start_i,
  input  logic [ADDR_W-1:0]  range_end_i,
  input  logic [TIME_W-1:0]  begin_time_i,
  input  logic [DUR_W-1:0]   run_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_kind_o,
  output logic [UNIT_W-1:0]  out_unit_o,
  output logic [COUNT_W-1:0] out_count_o,
  output logic [TIME_W-1:0]  out_time_o,
  output logic [ADDR_W-1:0]  out_start_o,
  output logic [ADDR_W-1:0]  out_end_o,
  output logic [DUR_W-1:0]   out_duration_o,
  output logic               out_last_o
);

  cmd_t cmd;
  sts_t sts;

  etrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  etrm_dp #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .PAGE_BITS   (PAGE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .unit_id_i      (unit_id_i),
    .range_start_i  (range_start_i),
    .range_end_i    (range_end_i),
    .begin_time_i   (begin_time_i),
    .run_time_i     (run_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_kind_o     (out_kind_o),
    .out_unit_o     (out_unit_o),
    .out_count_o    (out_count_o),
    .out_time_o     (out_time_o),
    .out_start_o    (out_start_o),
    .out_end_o      (out_end_o),
    .out_duration_o (out_duration_o),
    .out_last_o     (out_last_o)
  );

endmodule

// ===== rtl/etrm_ctrl.sv =====
// Sequencer: decides merge, append or packet emission and steps the emit burst.
module etrm_ctrl
  import etrm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   pend_apply_q, pend_apply_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_apply_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_apply_q <= pend_apply_d;
    end
  end

  // next state
  always_comb begin
    state_d      = state_q;
    pend_apply_d = pend_apply_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.flush) begin
          pend_apply_d = 1'b0;
          state_d      = sts_i.cnt_zero ? S_IDLE : S_HDR;
        end else if (sts_i.unit_chg) begin
          pend_apply_d = 1'b1;
          state_d      = S_HDR;
        end else begin
          pend_apply_d = 1'b0;
          state_d      = sts_i.fill ? S_HDR : S_IDLE;
        end
      end
      S_HDR: begin
        if (sts_i.out_free) state_d = S_ENT;
      end
      S_ENT: begin
        if (sts_i.out_free && sts_i.ent_last) state_d = S_BAR;
      end
      S_BAR: begin
        if (sts_i.out_free) state_d = pend_apply_q ? S_APPLY : S_IDLE;
      end
      S_APPLY: begin
        pend_apply_d = 1'b0;
        state_d      = sts_i.fill ? S_HDR : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      S_DECIDE: cmd_o.apply    = !sts_i.flush && !sts_i.unit_chg;
      S_HDR:    cmd_o.load_hdr = sts_i.out_free;
      S_ENT:    cmd_o.load_ent = sts_i.out_free;
      S_BAR:    cmd_o.load_bar = sts_i.out_free;
      S_APPLY:  cmd_o.apply    = 1'b1;
      default:  cmd_o          = '0;
    endcase
  end

endmodule

// ===== rtl/etrm_dp.sv =====
// Datapath: input latch, last-entry compare, entry memory and output register.
module etrm_dp
  import etrm_pkg::*;
#(
  parameter int unsigned CACHE_DEPTH = 32,
  parameter int unsigned PAGE_BITS   = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                req_type_i,
  input  logic [UNIT_W-1:0]   unit_id_i,
  input  logic [ADDR_W-1:0]   range_start_i,
  input  logic [ADDR_W-1:0]   range_end_i,
  input  logic [TIME_W-1:0]   begin_time_i,
  input  logic [DUR_W-1:0]    run_time_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          out_kind_o,
  output logic [UNIT_W-1:0]   out_unit_o,
  output logic [COUNT_W-1:0]  out_count_o,
  output logic [TIME_W-1:0]   out_time_o,
  output logic [ADDR_W-1:0]   out_start_o,
  output logic [ADDR_W-1:0]   out_end_o,
  output logic [DUR_W-1:0]    out_duration_o,
  output logic                out_last_o
);

  localparam int unsigned CW = $clog2(CACHE_DEPTH + 1);
  localparam int unsigned IW = $clog2(CACHE_DEPTH);

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
    logic [DUR_W-1:0]  dur;
  } entry_t;

  // configuration
  logic wide_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wide_q <= 1'b1;
    else if (cfg_we_i) wide_q <= cfg_wdata_i;
  end

  // accepted request
  logic              req_q;
  logic [UNIT_W-1:0] unit_q;
  logic [ADDR_W-1:0] s_q, e_q;
  logic [TIME_W-1:0] t_q;
  logic [DUR_W-1:0]  d_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q  <= req_type_i;
      unit_q <= unit_id_i;
      t_q    <= begin_time_i;
      d_q    <= run_time_i;
      s_q    <= wide_q ? range_start_i : {{HALF_W{1'b0}}, range_start_i[HALF_W-1:0]};
      e_q    <= wide_q ? range_end_i : {{HALF_W{1'b0}}, range_end_i[HALF_W-1:0]};
    end
  end

  // packet state
  logic [CW-1:0]     count_q, count_d;
  logic [UNIT_W-1:0] cur_unit_q, cur_unit_d;
  logic [TIME_W-1:0] pkt_time_q, pkt_time_d;
  entry_t            last_q, last_d;

  logic merge_hit;
  logic cnt_zero;
  logic [DUR_W-1:0] sum_dur;

  assign cnt_zero = (count_q == '0);
  assign sum_dur  = last_q.dur + d_q;
  assign merge_hit = !cnt_zero && (last_q.stop == s_q) && (last_q.start != last_q.stop) &&
                     (s_q != e_q) &&
                     (last_q.start[ADDR_W-1:PAGE_BITS] == last_q.stop[ADDR_W-1:PAGE_BITS]) &&
                     (s_q[ADDR_W-1:PAGE_BITS] == e_q[ADDR_W-1:PAGE_BITS]);

  // entry memory
  entry_t        mem_q [CACHE_DEPTH];
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  entry_t        wr_data;

  always_comb begin
    count_d    = count_q;
    cur_unit_d = cur_unit_q;
    pkt_time_d = pkt_time_q;
    last_d     = last_q;
    wr_en      = 1'b0;
    wr_idx     = IW'(count_q);
    wr_data    = '{start: s_q, stop: e_q, dur: d_q};
    if (cmd_i.apply) begin
      cur_unit_d = unit_q;
      if (cnt_zero) pkt_time_d = t_q;
      wr_en = 1'b1;
      if (merge_hit) begin
        wr_idx  = IW'(count_q - CW'(1));
        wr_data = '{start: last_q.start, stop: e_q, dur: sum_dur};
      end else begin
        count_d = count_q + CW'(1);
      end
      last_d = wr_data;
    end else if (cmd_i.load_bar) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      cur_unit_q <= '0;
      pkt_time_q <= '0;
    end else begin
      count_q    <= count_d;
      cur_unit_q <= cur_unit_d;
      pkt_time_q <= pkt_time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
  end

  // read side of the emit burst
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic          ent_last;
  entry_t        rd_data_q;

  assign ent_last = (CW'(rd_idx_q) == (count_q - CW'(1)));
  assign rd_addr  = cmd_i.load_hdr ? '0 : rd_idx_q + IW'(1);
  assign rd_en    = cmd_i.load_hdr || (cmd_i.load_ent && !ent_last);

  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.load_hdr) rd_idx_d = '0;
    else if (cmd_i.load_ent) rd_idx_d = rd_idx_q + IW'(1);
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    if (wr_en) mem_q[wr_idx] <= wr_data;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              out_load;
  kind_e             kind_q;
  logic [UNIT_W-1:0] o_unit_q;
  logic [COUNT_W-1:0] o_count_q;
  logic [TIME_W-1:0] o_time_q;
  entry_t            o_ent_q;
  logic              o_last_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = cmd_i.load_hdr || cmd_i.load_ent || cmd_i.load_bar;
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_unit_q <= cur_unit_q;
      if (cmd_i.load_hdr) begin
        kind_q    <= KIND_HEADER;
        o_count_q <= COUNT_W'(count_q);
        o_time_q  <= pkt_time_q;
        o_ent_q   <= '0;
        o_last_q  <= 1'b0;
      end else if (cmd_i.load_ent) begin
        kind_q    <= KIND_ENTRY;
        o_count_q <= '0;
        o_time_q  <= '0;
        o_ent_q   <= rd_data_q;
        o_last_q  <= 1'b0;
      end else begin
        kind_q    <= KIND_BARRIER;
        o_count_q <= '0;
        o_time_q  <= '0;
        o_ent_q   <= '0;
        o_last_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = kind_q;
  assign out_unit_o     = o_unit_q;
  assign out_count_o    = o_count_q;
  assign out_time_o     = o_time_q;
  assign out_start_o    = o_ent_q.start;
  assign out_end_o      = o_ent_q.stop;
  assign out_duration_o = o_ent_q.dur;
  assign out_last_o     = o_last_q;

  // status
  assign sts_o.flush    = (req_q == REQ_FLUSH);
  assign sts_o.cnt_zero = cnt_zero;
  assign sts_o.unit_chg = (unit_q != cur_unit_q) && !cnt_zero;
  assign sts_o.fill     = !merge_hit && (count_q == CW'(CACHE_DEPTH - 1));
  assign sts_o.ent_last = ent_last;
  assign sts_o.out_free = out_free;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CACHE_DEPTH))
    else $error("entry count above buffer depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten before transfer");

  a_apply_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |-> (count_q != CW'(CACHE_DEPTH)))
    else $error("record applied to full buffer");

  a_ent_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_ent |-> (!cnt_zero && (CW'(rd_idx_q) < count_q)))
    else $error("entry read beyond fill");

endmodule
